// File: hw/rtl/clamped_2d_convolution_top_macros.svh
// Assertion macros shared by the clamped convolution RTL.
`ifndef CLAMPED_2D_CONVOLUTION_TOP_MACROS_SVH
`define CLAMPED_2D_CONVOLUTION_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

`define CNV_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

`define CNV_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define CNV_ASSERT_IMP(label, ante, cons)

`define CNV_ASSERT_NXT(label, ante, cons)

`endif

`endif

// File: hw/rtl/cnv2d_pkg.sv
// Shared constants for the clamped convolution block.
package cnv2d_pkg;

  localparam int OPCODE_BITS    = 1;
  localparam int PIXEL_BITS     = 8;
  localparam int SUM_BITS       = 25;
  localparam int ROW_BITS       = 16;
  localparam int OUT_COL_BITS   = 10;
  localparam int WIDTH_REG_BITS = 11;
  localparam int CFG_DATA_BITS  = 64;
  localparam int CFG_INDEX_BITS = 3;
  localparam int KERNEL_ROWS    = 5;

  localparam int KERNEL_SIZE_DEFAULT = 3;
  localparam int MAX_WIDTH_DEFAULT   = 1024;
  localparam int COEFF_BITS_DEFAULT  = 12;

  localparam logic [OPCODE_BITS-1:0] OP_PIXEL = 1'b0;
  localparam logic [OPCODE_BITS-1:0] OP_DRAIN = 1'b1;

  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH      = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT     = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_KERNEL_ROW_ZERO  = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_KERNEL_ROW_ONE   = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_KERNEL_ROW_TWO   = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_KERNEL_ROW_THREE = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_KERNEL_ROW_FOUR  = 3'd6;

  localparam logic [WIDTH_REG_BITS-1:0] WIDTH_RESET  = 11'd1024;
  localparam logic [ROW_BITS-1:0]       HEIGHT_RESET = 16'd1;

endpackage

// File: hw/rtl/cnv2d_pixel_if.sv
// Input channel: pixel and drain items.
interface cnv2d_pixel_if;
  logic                                valid;
  logic                                ready;
  logic [cnv2d_pkg::OPCODE_BITS-1:0]   opcode;
  logic [cnv2d_pkg::PIXEL_BITS-1:0]    pixel;

  modport source(output valid, output opcode, output pixel, input ready);
  modport sink(input valid, input opcode, input pixel, output ready);
endinterface

// File: hw/rtl/cnv2d_result_if.sv
// Output channel: filtered pixels with their position.
interface cnv2d_result_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [cnv2d_pkg::SUM_BITS-1:0]   filtered;
  logic [cnv2d_pkg::ROW_BITS-1:0]          out_row;
  logic [cnv2d_pkg::OUT_COL_BITS-1:0]      out_col;
  logic                                    last_of_image;

  modport source(output valid, output filtered, output out_row, output out_col,
                 output last_of_image, input ready);
  modport sink(input valid, input filtered, input out_row, input out_col,
               input last_of_image, output ready);
endinterface

// File: hw/rtl/clamped_2d_convolution_top.sv
// Top level of the clamped 2D convolution block.
`include "clamped_2d_convolution_top_macros.svh"

// Takes one item per clock (pixel or drain); the item that releases a filtered pixel sends it
// through the read, product, row-sum and output registers; throughput stays one item per clock
// as long as the result side takes a transfer every clock. The line memory is split into
// (2*(K/2)+2) row banks by (2*(K/2)+1) column banks, each with one write and one read port,
// so a whole K by K neighborhood is read in the same clock; the pixel being written in that
// clock is forwarded. Edge pixels are replicated by remapping window taps, not by extra reads.
// The line memory needs no clearing after reset; it is written before it is read.
module clamped_2d_convolution_top #(
  parameter int KERNEL_SIZE = cnv2d_pkg::KERNEL_SIZE_DEFAULT,
  parameter int MAX_WIDTH   = cnv2d_pkg::MAX_WIDTH_DEFAULT,
  parameter int COEFF_BITS  = cnv2d_pkg::COEFF_BITS_DEFAULT
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_write,
  input  logic [cnv2d_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [cnv2d_pkg::CFG_DATA_BITS-1:0]     cfg_data,
  cnv2d_pixel_if.sink                             pixels,
  cnv2d_result_if.source                          results
);

  localparam int HALF         = KERNEL_SIZE / 2;
  localparam int TAPS         = 2 * HALF + 1;
  localparam int ROWS         = TAPS + 1;
  localparam int COL_BITS     = $clog2(MAX_WIDTH);
  localparam int WBITS        = COL_BITS + 1;
  localparam int DEPTH        = (MAX_WIDTH + TAPS - 1) / TAPS;
  localparam int ADDR_BITS    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int MEM_DEPTH    = 1 << ADDR_BITS;
  localparam int TAP_BITS     = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int RSEL_BITS    = $clog2(ROWS);
  localparam int PEND_BITS    = $clog2(HALF * MAX_WIDTH + HALF + 2) + 1;
  localparam int PROD_BITS    = cnv2d_pkg::PIXEL_BITS + COEFF_BITS + 1;
  localparam int PIX          = cnv2d_pkg::PIXEL_BITS;
  localparam int RB           = cnv2d_pkg::ROW_BITS;
  localparam int SB           = cnv2d_pkg::SUM_BITS;

  // configuration registers
  logic [cnv2d_pkg::WIDTH_REG_BITS-1:0] width_reg;
  logic [RB-1:0]                        height_reg;
  logic [cnv2d_pkg::CFG_DATA_BITS-1:0]  kernel [cnv2d_pkg::KERNEL_ROWS];

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= cnv2d_pkg::WIDTH_RESET;
      height_reg <= cnv2d_pkg::HEIGHT_RESET;
      for (int i = 0; i < cnv2d_pkg::KERNEL_ROWS; i++) kernel[i] <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        cnv2d_pkg::REG_IMAGE_WIDTH:      width_reg <= cfg_data[cnv2d_pkg::WIDTH_REG_BITS-1:0];
        cnv2d_pkg::REG_IMAGE_HEIGHT:     height_reg <= cfg_data[RB-1:0];
        cnv2d_pkg::REG_KERNEL_ROW_ZERO:  kernel[0] <= cfg_data;
        cnv2d_pkg::REG_KERNEL_ROW_ONE:   kernel[1] <= cfg_data;
        cnv2d_pkg::REG_KERNEL_ROW_TWO:   kernel[2] <= cfg_data;
        cnv2d_pkg::REG_KERNEL_ROW_THREE: kernel[3] <= cfg_data;
        cnv2d_pkg::REG_KERNEL_ROW_FOUR:  kernel[4] <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [WBITS-1:0] w_eff;
  logic [RB-1:0]    h_eff;
  logic [PEND_BITS-1:0] lag;

  always_comb begin
    if (width_reg == '0) begin
      w_eff = WBITS'(1);
    end else if (32'(width_reg) > 32'(MAX_WIDTH)) begin
      w_eff = WBITS'(MAX_WIDTH);
    end else begin
      w_eff = WBITS'(width_reg);
    end
    h_eff = (height_reg == '0) ? RB'(1) : height_reg;
    lag   = PEND_BITS'(HALF * 32'(w_eff) + HALF);
  end

  // counters
  logic [RB-1:0]        in_row, out_row;
  logic [COL_BITS-1:0]  in_col, out_col;
  logic [RSEL_BITS-1:0] in_rbank, out_rbank;
  logic [TAP_BITS-1:0]  in_cmod, out_cmod;
  logic [ADDR_BITS-1:0] in_cdiv, out_cdiv;
  logic [PEND_BITS-1:0] pending;

  logic out_valid, en, acc, is_pix, done, write_en;
  logic in_wrap, out_wrap, done_after, emit, clear_only, produce, res_last;
  logic counters_zero;

  assign en           = !out_valid || results.ready;
  assign pixels.ready = en;
  assign acc          = pixels.valid && en;
  assign is_pix       = (pixels.opcode == cnv2d_pkg::OP_PIXEL);
  assign done         = (in_row >= h_eff);
  assign write_en     = acc && is_pix && !done;
  assign in_wrap      = (32'(in_col) + 1 >= 32'(w_eff));
  assign out_wrap     = (32'(out_col) + 1 >= 32'(w_eff));
  assign done_after   = (32'(in_row) + (in_wrap ? 32'd1 : 32'd0) >= 32'(h_eff));

  always_comb begin
    if (is_pix) begin
      emit = acc && !done && (done_after || (pending + PEND_BITS'(1) > lag));
    end else begin
      emit = acc && done;
    end
    clear_only = emit && (out_row >= h_eff);
    produce    = emit && !clear_only;
    res_last   = produce && (32'(out_row) + (out_wrap ? 32'd1 : 32'd0) >= 32'(h_eff));
  end

  always_ff @(posedge clk) begin
    if (rst || clear_only || res_last) begin
      in_row    <= '0;
      in_col    <= '0;
      in_rbank  <= '0;
      in_cmod   <= '0;
      in_cdiv   <= '0;
      out_row   <= '0;
      out_col   <= '0;
      out_rbank <= '0;
      out_cmod  <= '0;
      out_cdiv  <= '0;
      pending   <= '0;
    end else begin
      if (write_en) begin
        if (in_wrap) begin
          in_col  <= '0;
          in_cmod <= '0;
          in_cdiv <= '0;
          in_row  <= in_row + RB'(1);
          in_rbank <= (32'(in_rbank) == ROWS - 1) ? '0 : in_rbank + RSEL_BITS'(1);
        end else begin
          in_col <= in_col + COL_BITS'(1);
          if (32'(in_cmod) == TAPS - 1) begin
            in_cmod <= '0;
            in_cdiv <= in_cdiv + ADDR_BITS'(1);
          end else begin
            in_cmod <= in_cmod + TAP_BITS'(1);
          end
        end
      end
      if (produce) begin
        if (out_wrap) begin
          out_col  <= '0;
          out_cmod <= '0;
          out_cdiv <= '0;
          out_row  <= out_row + RB'(1);
          out_rbank <= (32'(out_rbank) == ROWS - 1) ? '0 : out_rbank + RSEL_BITS'(1);
        end else begin
          out_col <= out_col + COL_BITS'(1);
          if (32'(out_cmod) == TAPS - 1) begin
            out_cmod <= '0;
            out_cdiv <= out_cdiv + ADDR_BITS'(1);
          end else begin
            out_cmod <= out_cmod + TAP_BITS'(1);
          end
        end
      end
      if (write_en && !produce) begin
        pending <= pending + PEND_BITS'(1);
      end else if (produce && !write_en) begin
        pending <= pending - PEND_BITS'(1);
      end
    end
  end

  // window addressing: column bank and address per tap, edge remap per tap
  logic [TAP_BITS-1:0]  cb_mod  [TAPS];
  logic [ADDR_BITS-1:0] cb_div  [TAPS];
  logic [ADDR_BITS-1:0] rd_addr [TAPS];
  logic [TAP_BITS-1:0]  col_sel [TAPS];
  logic [RSEL_BITS-1:0] row_sel [TAPS];

  always_comb begin
    int t, y, x, v, src;
    for (int b = 0; b < TAPS; b++) begin
      t = int'(out_cmod) + b - HALF;
      if (t < 0) begin
        cb_mod[b] = TAP_BITS'(t + TAPS);
        cb_div[b] = out_cdiv - ADDR_BITS'(1);
      end else if (t >= TAPS) begin
        cb_mod[b] = TAP_BITS'(t - TAPS);
        cb_div[b] = out_cdiv + ADDR_BITS'(1);
      end else begin
        cb_mod[b] = TAP_BITS'(t);
        cb_div[b] = out_cdiv;
      end
    end
    for (int j = 0; j < TAPS; j++) rd_addr[j] = '0;
    for (int b = 0; b < TAPS; b++) rd_addr[cb_mod[b]] = cb_div[b];
    for (int b = 0; b < TAPS; b++) begin
      y = int'(out_col) + b - HALF;
      if (y < 0) y = 0;
      if (y > int'(w_eff) - 1) y = int'(w_eff) - 1;
      src = y - int'(out_col) + HALF;
      col_sel[b] = cb_mod[TAP_BITS'(src)];
    end
    for (int a = 0; a < TAPS; a++) begin
      x = int'(out_row) + a - HALF;
      if (x < 0) x = 0;
      if (x > int'(h_eff) - 1) x = int'(h_eff) - 1;
      src = x - int'(out_row) + HALF;
      v = int'(out_rbank) + ROWS - HALF + src;
      if (v >= ROWS) v = v - ROWS;
      if (v >= ROWS) v = v - ROWS;
      row_sel[a] = RSEL_BITS'(v);
    end
  end

  // banked line memory
  logic [PIX-1:0] line_mem [ROWS][TAPS][MEM_DEPTH];
  logic [PIX-1:0] rdata    [ROWS][TAPS];

  for (genvar s = 0; s < ROWS; s++) begin : g_row_bank
    for (genvar j = 0; j < TAPS; j++) begin : g_col_bank
      always_ff @(posedge clk) begin
        if (write_en && 32'(in_rbank) == s && 32'(in_cmod) == j) begin
          line_mem[s][j][in_cdiv] <= pixels.pixel;
        end
        if (en) begin
          rdata[s][j] <= line_mem[s][j][rd_addr[j]];
        end
      end
    end
  end

  // stage 1: read data, forwarding of the same-clock write
  logic                 s1_valid, s1_last;
  logic [RB-1:0]        s1_row;
  logic [COL_BITS-1:0]  s1_col;
  logic [TAP_BITS-1:0]  s1_colsel [TAPS];
  logic [RSEL_BITS-1:0] s1_rowsel [TAPS];
  logic [ADDR_BITS-1:0] rd_addr_q [TAPS];
  logic                 fw_valid;
  logic [RSEL_BITS-1:0] fw_rbank;
  logic [TAP_BITS-1:0]  fw_cmod;
  logic [ADDR_BITS-1:0] fw_addr;
  logic [PIX-1:0]       fw_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fw_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= produce;
      fw_valid <= write_en;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_last  <= res_last;
      s1_row   <= out_row;
      s1_col   <= out_col;
      fw_rbank <= in_rbank;
      fw_cmod  <= in_cmod;
      fw_addr  <= in_cdiv;
      fw_data  <= pixels.pixel;
      for (int i = 0; i < TAPS; i++) begin
        s1_colsel[i] <= col_sel[i];
        s1_rowsel[i] <= row_sel[i];
        rd_addr_q[i] <= rd_addr[i];
      end
    end
  end

  logic [PIX-1:0] bank_data [ROWS][TAPS];
  logic [PIX-1:0] window    [TAPS][TAPS];

  always_comb begin
    for (int s = 0; s < ROWS; s++) begin
      for (int j = 0; j < TAPS; j++) begin
        if (fw_valid && 32'(fw_rbank) == s && 32'(fw_cmod) == j && fw_addr == rd_addr_q[j]) begin
          bank_data[s][j] = fw_data;
        end else begin
          bank_data[s][j] = rdata[s][j];
        end
      end
    end
    for (int a = 0; a < TAPS; a++) begin
      for (int b = 0; b < TAPS; b++) begin
        window[a][b] = bank_data[s1_rowsel[a]][s1_colsel[b]];
      end
    end
  end

  // coefficients, zero outside the kernel
  logic signed [COEFF_BITS-1:0] coeff [TAPS][TAPS];

  for (genvar a = 0; a < TAPS; a++) begin : g_coeff_row
    for (genvar b = 0; b < TAPS; b++) begin : g_coeff_col
      if (a < KERNEL_SIZE && b < KERNEL_SIZE) begin : g_used
        assign coeff[a][b] = kernel[a][b*COEFF_BITS +: COEFF_BITS];
      end else begin : g_zero
        assign coeff[a][b] = '0;
      end
    end
  end

  // stage 2: products
  logic                        s2_valid, s2_last;
  logic [RB-1:0]               s2_row;
  logic [COL_BITS-1:0]         s2_col;
  logic signed [PROD_BITS-1:0] prod [TAPS][TAPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_last <= s1_last;
      s2_row  <= s1_row;
      s2_col  <= s1_col;
      for (int a = 0; a < TAPS; a++) begin
        for (int b = 0; b < TAPS; b++) begin
          prod[a][b] <= PROD_BITS'(signed'({1'b0, window[a][b]})) * PROD_BITS'(coeff[a][b]);
        end
      end
    end
  end

  // stage 3: row sums
  logic                 s3_valid, s3_last;
  logic [RB-1:0]        s3_row;
  logic [COL_BITS-1:0]  s3_col;
  logic signed [SB-1:0] row_sum [TAPS];
  logic signed [SB-1:0] row_sum_next [TAPS];

  always_comb begin
    for (int a = 0; a < TAPS; a++) begin
      row_sum_next[a] = '0;
      for (int b = 0; b < TAPS; b++) begin
        row_sum_next[a] = row_sum_next[a] + SB'(prod[a][b]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_last <= s2_last;
      s3_row  <= s2_row;
      s3_col  <= s2_col;
      for (int a = 0; a < TAPS; a++) row_sum[a] <= row_sum_next[a];
    end
  end

  // stage 4: output register
  logic signed [SB-1:0] total_next;

  always_comb begin
    total_next = '0;
    for (int a = 0; a < TAPS; a++) total_next = total_next + row_sum[a];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      results.filtered      <= total_next;
      results.out_row       <= s3_row;
      results.out_col       <= cnv2d_pkg::OUT_COL_BITS'(32'(s3_col));
      results.last_of_image <= s3_last;
    end
  end

  assign results.valid = out_valid;

  assign counters_zero = (in_row == '0) && (in_col == '0) && (out_row == '0) &&
                         (out_col == '0) && (pending == '0);

  `CNV_ASSERT_NXT(a_early_drain_silent, acc && !is_pix && !done, !s1_valid)
  `CNV_ASSERT_NXT(a_last_clears, acc && res_last, counters_zero)
  `CNV_ASSERT_IMP(a_out_from_pipe, $rose(out_valid), $past(s3_valid))

endmodule

// File: tb/clamped_2d_convolution_top_test.sv
// Self-checking testbench of the clamped 2D convolution block with its own pixel-window predictor.
module clamped_2d_convolution_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [cnv2d_pkg::OPCODE_BITS-1:0] opcode;
    logic [cnv2d_pkg::PIXEL_BITS-1:0]  pixel;
  } item_t;

  typedef struct packed {
    logic signed [cnv2d_pkg::SUM_BITS-1:0] filtered;
    logic [cnv2d_pkg::ROW_BITS-1:0]        out_row;
    logic [cnv2d_pkg::OUT_COL_BITS-1:0]    out_col;
    logic                                  last_of_image;
  } pix_out_t;

  localparam int HALF_K     = cnv2d_pkg::KERNEL_SIZE_DEFAULT / 2;
  localparam int TAPS       = 2 * HALF_K + 1;
  localparam int LINES      = TAPS + 1;
  localparam int CBITS      = cnv2d_pkg::COEFF_BITS_DEFAULT;
  localparam int DUT_LAT    = 20;
  localparam int IDX_W      = cnv2d_pkg::CFG_INDEX_BITS;
  localparam int DATA_W     = cnv2d_pkg::CFG_DATA_BITS;
  localparam int PIX_W      = cnv2d_pkg::PIXEL_BITS;

  logic clk;
  logic rst;
  logic cfg_write;
  logic [IDX_W-1:0]  cfg_index;
  logic [DATA_W-1:0] cfg_data;

  cnv2d_pixel_if  pix_ch();
  cnv2d_result_if res_ch();

  clamped_2d_convolution_top i_dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pixels(pix_ch.sink), .results(res_ch.source)
  );

  item_t    pending_items[$];
  pix_out_t expected_pixels[$];
  int       errors = 0;
  bit       quiet = 0;
  bit       hold_go = 0;
  bit       long_hold = 0;
  int       gap_left = 0;
  int       stall_left = 0;

  // predictor state
  logic [cnv2d_pkg::WIDTH_REG_BITS-1:0] width_reg;
  logic [cnv2d_pkg::ROW_BITS-1:0]       height_reg;
  logic [DATA_W-1:0]                    kernel_reg [cnv2d_pkg::KERNEL_ROWS];
  logic [PIX_W-1:0]                     line_mem [LINES][cnv2d_pkg::MAX_WIDTH_DEFAULT];
  int in_row, in_col, out_row, out_col;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  function automatic int eff_width();
    if (width_reg == 0) return 1;
    if (width_reg > cnv2d_pkg::MAX_WIDTH_DEFAULT) return cnv2d_pkg::MAX_WIDTH_DEFAULT;
    return int'(width_reg);
  endfunction

  function automatic int eff_height();
    return (height_reg == 0) ? 1 : int'(height_reg);
  endfunction

  function automatic longint tap_coeff(input int a, input int b);
    logic signed [CBITS-1:0] c;
    if (a >= cnv2d_pkg::KERNEL_SIZE_DEFAULT || b >= cnv2d_pkg::KERNEL_SIZE_DEFAULT) return 0;
    c = kernel_reg[a][b*CBITS +: CBITS];
    return longint'(c);
  endfunction

  function automatic void clear_positions();
    in_row = 0; in_col = 0; out_row = 0; out_col = 0;
  endfunction

  task automatic predict_pixel(input item_t it);
    int w, h, x, y;
    bit done, emit;
    longint recv, nxt, sum;
    pix_out_t e;
    w = eff_width();
    h = eff_height();
    done = in_row >= h;
    if (it.opcode == cnv2d_pkg::OP_PIXEL) begin
      if (done) return;
      line_mem[in_row % LINES][in_col] = it.pixel;
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
      end
      done = in_row >= h;
      recv = longint'(in_row) * w + in_col;
      nxt = longint'(out_row) * w + out_col;
      emit = done || recv >= nxt + HALF_K * w + HALF_K + 1;
    end else begin
      emit = done;
    end
    if (!emit) return;
    if (out_row >= h) begin
      clear_positions();
      return;
    end
    sum = 0;
    for (int a = 0; a < TAPS; a++) begin
      x = out_row + a - HALF_K;
      if (x < 0) x = 0;
      if (x > h - 1) x = h - 1;
      for (int b = 0; b < TAPS; b++) begin
        y = out_col + b - HALF_K;
        if (y < 0) y = 0;
        if (y > w - 1) y = w - 1;
        sum += longint'(line_mem[x % LINES][y]) * tap_coeff(a, b);
      end
    end
    e.filtered = sum[cnv2d_pkg::SUM_BITS-1:0];
    e.out_row = out_row[cnv2d_pkg::ROW_BITS-1:0];
    e.out_col = out_col[cnv2d_pkg::OUT_COL_BITS-1:0];
    e.last_of_image = 1'b0;
    out_col++;
    if (out_col >= w) begin
      out_col = 0;
      out_row++;
    end
    if (out_row >= h) begin
      e.last_of_image = 1'b1;
      clear_positions();
    end
    expected_pixels.push_back(e);
  endtask

  task automatic queue_item(input logic [cnv2d_pkg::OPCODE_BITS-1:0] op,
                            input logic [PIX_W-1:0] px);
    item_t it;
    it.opcode = op;
    it.pixel = px;
    predict_pixel(it);
    pending_items.push_back(it);
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_items.size() != 0 || pix_ch.valid || expected_pixels.size() != 0);
    repeat (DUT_LAT) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx,
                           input logic [DATA_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == cnv2d_pkg::REG_IMAGE_WIDTH)
      width_reg = val[cnv2d_pkg::WIDTH_REG_BITS-1:0];
    else if (idx == cnv2d_pkg::REG_IMAGE_HEIGHT)
      height_reg = val[cnv2d_pkg::ROW_BITS-1:0];
    else kernel_reg[idx - cnv2d_pkg::REG_KERNEL_ROW_ZERO] = val;
  endtask

  // mode 0: random, 1: all most negative, 2: all most positive
  task automatic load_kernel(input int mode);
    logic [DATA_W-1:0] v;
    for (int r = 0; r < cnv2d_pkg::KERNEL_ROWS; r++) begin
      v = {$urandom, $urandom};
      for (int b = 0; b < 5; b++) begin
        if (mode == 1) v[b*CBITS +: CBITS] = {1'b1, {(CBITS-1){1'b0}}};
        else if (mode == 2) v[b*CBITS +: CBITS] = {1'b0, {(CBITS-1){1'b1}}};
      end
      write_reg(IDX_W'(int'(cnv2d_pkg::REG_KERNEL_ROW_ZERO) + r), v);
    end
  endtask

  // pmode 0: random pixels, 1: alternating extremes
  task automatic run_image(input int w, input int h, input int pmode, input int noise);
    int n;
    write_reg(cnv2d_pkg::REG_IMAGE_WIDTH, DATA_W'(w));
    write_reg(cnv2d_pkg::REG_IMAGE_HEIGHT, DATA_W'(h));
    n = eff_width() * eff_height();
    for (int i = 0; i < n; i++) begin
      if (noise != 0 && $urandom_range(0, 9) == 0) queue_item(cnv2d_pkg::OP_DRAIN, PIX_W'($urandom));
      if (pmode == 1) queue_item(cnv2d_pkg::OP_PIXEL, (i % 2) ? 8'hff : 8'h00);
      else queue_item(cnv2d_pkg::OP_PIXEL, PIX_W'($urandom));
    end
    while (in_row >= eff_height()) begin
      if (noise != 0 && $urandom_range(0, 5) == 0) queue_item(cnv2d_pkg::OP_PIXEL, PIX_W'($urandom));
      queue_item(cnv2d_pkg::OP_DRAIN, PIX_W'($urandom));
    end
    if (noise != 0) queue_item(cnv2d_pkg::OP_DRAIN, PIX_W'($urandom));
    wait_idle();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pix_ch.valid <= 1'b0;
      gap_left <= 0;
    end else if (!pix_ch.valid || pix_ch.ready) begin
      if (gap_left > 0) begin
        pix_ch.valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_items.size() != 0) begin
        pix_ch.valid <= 1'b1;
        pix_ch.opcode <= pending_items[0].opcode;
        pix_ch.pixel <= pending_items[0].pixel;
        void'(pending_items.pop_front());
        if (!quiet && $urandom_range(0, 7) == 0) gap_left <= $urandom_range(1, 3);
      end else begin
        pix_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    pix_out_t e;
    if (rst) begin
      res_ch.ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (expected_pixels.size() == 0) begin
          report("unexpected result transfer");
        end else begin
          e = expected_pixels.pop_front();
          if (res_ch.filtered !== e.filtered)
            report($sformatf("filtered %0d, want %0d", res_ch.filtered, e.filtered));
          if (res_ch.out_row !== e.out_row)
            report($sformatf("out_row %0d, want %0d", res_ch.out_row, e.out_row));
          if (res_ch.out_col !== e.out_col)
            report($sformatf("out_col %0d, want %0d", res_ch.out_col, e.out_col));
          if (res_ch.last_of_image !== e.last_of_image)
            report($sformatf("last_of_image %0b, want %0b", res_ch.last_of_image,
                             e.last_of_image));
        end
      end
      if (long_hold) begin
        res_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        res_ch.ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        res_ch.ready <= 1'b0;
        stall_left <= $urandom_range(0, 2);
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    wait (hold_go);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (300) @(posedge clk);
    long_hold <= 1'b0;
  end

  initial begin
    #5ms;
    $display("clamped_2d_convolution_top_test failed");
    $finish;
  end

  initial begin
    int w, h, km, sent;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    pix_ch.valid = 1'b0;
    pix_ch.opcode = cnv2d_pkg::OP_PIXEL;
    pix_ch.pixel = '0;
    res_ch.ready = 1'b0;
    width_reg = cnv2d_pkg::WIDTH_RESET;
    height_reg = cnv2d_pkg::HEIGHT_RESET;
    for (int r = 0; r < cnv2d_pkg::KERNEL_ROWS; r++) kernel_reg[r] = '0;
    for (int l = 0; l < LINES; l++)
      for (int c = 0; c < cnv2d_pkg::MAX_WIDTH_DEFAULT; c++) line_mem[l][c] = '0;
    clear_positions();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // directed
    load_kernel(2);
    queue_item(cnv2d_pkg::OP_DRAIN, 8'h00);
    wait_idle();
    run_image(3, 3, 1, 1);
    load_kernel(1);
    run_image(1, 1, 1, 1);
    run_image(0, 0, 1, 0);
    load_kernel(0);
    run_image(100, 2, 0, 0);
    run_image(2, 3, 0, 1);

    sent = 0;
    while (sent < 560) begin
      w = $urandom_range(1, 12);
      h = $urandom_range(1, 8);
      km = $urandom_range(0, 9);
      load_kernel(km < 8 ? 0 : km - 7);
      if (sent > 420) quiet = 1;
      if (sent > 100 && !hold_go) hold_go = 1;
      run_image(w, h, $urandom_range(0, 5) == 0, $urandom_range(0, 3) != 0);
      sent += w * h + 2 * w;
    end

    wait_idle();
    if (errors == 0) begin
      $display("clamped_2d_convolution_top_test passed");
    end else begin
      $display("clamped_2d_convolution_top_test failed");
    end
    $finish;
  end
endmodule
